[hdl/particle_wall_boundary_classifier_top_assert.svh]
// Assertion macros used by the boundary classifier top level.
`ifndef PARTICLE_WALL_BOUNDARY_CLASSIFIER_TOP_ASSERT_SVH
`define PARTICLE_WALL_BOUNDARY_CLASSIFIER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PWBC_ASSERT_SAME(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PWBC_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hdl/pwbc_pkg.sv]
// Types and constants shared by the boundary classifier modules.
package pwbc_pkg;

    localparam int unsigned NUM_AXES = 3;

    // configuration register indexes
    localparam logic [2:0] CFG_PERIODIC_MASK = 3'd0;
    localparam logic [2:0] CFG_DOMAIN_LEN_X  = 3'd1;
    localparam logic [2:0] CFG_DOMAIN_LEN_Y  = 3'd2;
    localparam logic [2:0] CFG_DOMAIN_LEN_Z  = 3'd3;
    localparam logic [2:0] CFG_SUB_BOUNDS_X  = 3'd4;
    localparam logic [2:0] CFG_SUB_BOUNDS_Y  = 3'd5;
    localparam logic [2:0] CFG_SUB_BOUNDS_Z  = 3'd6;

    // image shift codes per axis
    localparam logic [1:0] SHIFT_NONE  = 2'd0;
    localparam logic [1:0] SHIFT_PLUS  = 2'd1;
    localparam logic [1:0] SHIFT_MINUS = 2'd2;

    // neighbour direction per axis
    localparam logic [1:0] DIR_BELOW  = 2'd0;
    localparam logic [1:0] DIR_INSIDE = 2'd1;
    localparam logic [1:0] DIR_ABOVE  = 2'd2;

    localparam logic [4:0] STAY_TAG = 5'd13;
    localparam logic [4:0] MAX_TAG  = 5'd26;

    typedef struct packed {
        logic               periodic;
        logic        [30:0] len;
        logic signed [31:0] lo;
        logic signed [31:0] hi;
    } t_axis_cfg;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] aux;
        logic signed [31:0] vel;
    } t_lane_in;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] aux;
        logic signed [31:0] vel;
        logic signed [31:0] pos_wrap;
        logic signed [31:0] aux_wrap;
        logic        [1:0]  code;
        logic        [1:0]  dir;
        logic               periodic;
    } t_lane_out;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic out;
    } t_pipe_en;

endpackage

[hdl/pwbc_lane.sv]
// One axis lane: wall reflection, subdomain compare and periodic wrap candidate.
module pwbc_lane
    import pwbc_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic      i_clk,
    input  t_pipe_en  i_en,
    input  logic      i_phase,
    input  t_lane_in  i_in,
    input  t_axis_cfg i_cfg,
    output t_lane_out o_out
);

    localparam int SAT_W = (POS_WIDTH < 32) ? POS_WIDTH : 32;
    localparam logic signed [33:0] SAT_HI = (34'sd1 <<< (SAT_W - 1)) - 34'sd1;
    localparam logic signed [33:0] SAT_LO = -SAT_HI - 34'sd1;

    function automatic logic signed [31:0] f_sat(input logic signed [33:0] x);
        logic signed [33:0] y;
        if (x > SAT_HI) begin
            y = SAT_HI;
        end else if (x < SAT_LO) begin
            y = SAT_LO;
        end else begin
            y = x;
        end
        return y[31:0];
    endfunction

    function automatic logic signed [33:0] f_ext(input logic signed [31:0] x);
        return {{2{x[31]}}, x};
    endfunction

    logic signed [33:0] len_ext;
    assign len_ext = {3'b000, i_cfg.len};

    // stage 1: low wall
    logic               r_s1_phase, n_s1_phase;
    logic signed [31:0] r_s1_pos, n_s1_pos;
    logic signed [31:0] r_s1_aux, n_s1_aux;
    logic signed [31:0] r_s1_vel, n_s1_vel;
    logic signed [31:0] q0;
    logic               low_hit;

    always_comb begin
        q0         = i_phase ? i_in.aux : i_in.pos;
        low_hit    = !i_cfg.periodic && q0[31];
        n_s1_phase = i_phase;
        n_s1_pos   = (low_hit && !i_phase) ? f_sat(-f_ext(q0)) : i_in.pos;
        n_s1_aux   = (low_hit && i_phase) ? f_sat(-f_ext(q0)) : i_in.aux;
        n_s1_vel   = low_hit ? f_sat(-f_ext(i_in.vel)) : i_in.vel;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s1) begin
            r_s1_phase <= n_s1_phase;
            r_s1_pos   <= n_s1_pos;
            r_s1_aux   <= n_s1_aux;
            r_s1_vel   <= n_s1_vel;
        end
    end

    // stage 2: high wall, judged on the result of the low wall
    logic signed [31:0] r_s2_pos, n_s2_pos;
    logic signed [31:0] r_s2_aux, n_s2_aux;
    logic signed [31:0] r_s2_vel, n_s2_vel;
    logic signed [31:0] q1;
    logic signed [31:0] q1_refl;
    logic               high_hit;

    always_comb begin
        q1       = r_s1_phase ? r_s1_aux : r_s1_pos;
        high_hit = !i_cfg.periodic && (f_ext(q1) >= len_ext);
        q1_refl  = f_sat((len_ext <<< 1) - f_ext(q1));
        n_s2_pos = (high_hit && !r_s1_phase) ? q1_refl : r_s1_pos;
        n_s2_aux = (high_hit && r_s1_phase) ? q1_refl : r_s1_aux;
        n_s2_vel = high_hit ? f_sat(-f_ext(r_s1_vel)) : r_s1_vel;
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s2) begin
            r_s2_pos <= n_s2_pos;
            r_s2_aux <= n_s2_aux;
            r_s2_vel <= n_s2_vel;
        end
    end

    // stage 3: subdomain direction and wrap candidate
    t_lane_out          r_s3, n_s3;
    logic               wrap_neg;
    logic               wrap_pos;
    logic signed [31:0] pw1;
    logic signed [31:0] aw1;

    always_comb begin
        wrap_neg = r_s2_pos[31];
        pw1      = wrap_neg ? f_sat(f_ext(r_s2_pos) + len_ext) : r_s2_pos;
        aw1      = wrap_neg ? f_sat(f_ext(r_s2_aux) + len_ext) : r_s2_aux;
        wrap_pos = f_ext(pw1) >= len_ext;

        n_s3.pos      = r_s2_pos;
        n_s3.aux      = r_s2_aux;
        n_s3.vel      = r_s2_vel;
        n_s3.pos_wrap = wrap_pos ? f_sat(f_ext(pw1) - len_ext) : pw1;
        n_s3.aux_wrap = wrap_pos ? f_sat(f_ext(aw1) - len_ext) : aw1;
        n_s3.periodic = i_cfg.periodic;

        priority if (wrap_pos) begin
            n_s3.code = SHIFT_PLUS;
        end else if (wrap_neg) begin
            n_s3.code = SHIFT_MINUS;
        end else begin
            n_s3.code = SHIFT_NONE;
        end

        // below-low wins over at-or-above-high when the bounds are inverted
        priority if (r_s2_pos < i_cfg.lo) begin
            n_s3.dir = DIR_BELOW;
        end else if (r_s2_pos >= i_cfg.hi) begin
            n_s3.dir = DIR_ABOVE;
        end else begin
            n_s3.dir = DIR_INSIDE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en.s3) begin
            r_s3 <= n_s3;
        end
    end

    assign o_out = r_s3;

endmodule

[hdl/pwbc_merge.sv]
// Merge stage: forms the neighbour tag and applies the wrap on leaving particles.
module pwbc_merge
    import pwbc_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_en,
    input  t_lane_out          i_lane [NUM_AXES],
    output logic signed [31:0] o_pos  [NUM_AXES],
    output logic signed [31:0] o_aux  [NUM_AXES],
    output logic signed [31:0] o_vel  [NUM_AXES],
    output logic        [5:0]  o_image_shift,
    output logic        [4:0]  o_neighbour_tag
);

    logic signed [31:0] r_pos [NUM_AXES];
    logic signed [31:0] r_aux [NUM_AXES];
    logic signed [31:0] r_vel [NUM_AXES];
    logic signed [31:0] n_pos [NUM_AXES];
    logic signed [31:0] n_aux [NUM_AXES];
    logic        [5:0]  r_shift, n_shift;
    logic        [4:0]  r_tag, n_tag;
    logic               leaving;
    logic               do_wrap [NUM_AXES];

    always_comb begin
        n_tag = 5'(i_lane[0].dir) * 5'd9 + 5'(i_lane[1].dir) * 5'd3 + 5'(i_lane[2].dir);
        leaving = (n_tag != STAY_TAG);
        n_shift = '0;
        for (int ax = 0; ax < NUM_AXES; ax++) begin
            do_wrap[ax] = leaving && i_lane[ax].periodic;
            n_pos[ax]   = do_wrap[ax] ? i_lane[ax].pos_wrap : i_lane[ax].pos;
            n_aux[ax]   = do_wrap[ax] ? i_lane[ax].aux_wrap : i_lane[ax].aux;
            n_shift[2*ax +: 2] = do_wrap[ax] ? i_lane[ax].code : SHIFT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_pos[ax] <= n_pos[ax];
                r_aux[ax] <= n_aux[ax];
                r_vel[ax] <= i_lane[ax].vel;
            end
            r_shift <= n_shift;
            r_tag   <= n_tag;
        end
    end

    assign o_pos           = r_pos;
    assign o_aux           = r_aux;
    assign o_vel           = r_vel;
    assign o_image_shift   = r_shift;
    assign o_neighbour_tag = r_tag;

endmodule

[hdl/particle_wall_boundary_classifier_top.sv]
// Top level of the particle wall and subdomain boundary classifier.
//
// Input channel: i_in_valid / o_in_stall with phase, main position, auxiliary
// position and velocity per axis. Output channel: o_out_valid / i_out_stall
// with the updated positions and velocity, image shift and neighbour tag.
// One result leaves for every item taken, in order.
// Configuration: i_cfg_valid / o_cfg_ready with a 3-bit register index and
// 64-bit data; ready is always high and unknown indexes are ignored. Write
// only while no item is in flight.
// An item passes three stages in each of the three axis lanes, then one merge
// register, to o_out_valid; throughput is one item per cycle while i_out_stall
// is low. A stalled receiver holds the output register; stages behind it keep
// filling bubbles, so o_in_stall rises only when every stage is full.
// Synchronous reset clears the pipeline valid flags and all configuration
// registers to zero; no clearing pass is needed.
module particle_wall_boundary_classifier_top
    import pwbc_pkg::*;
#(
    parameter int POS_WIDTH = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic        [2:0]  i_cfg_index,
    input  logic        [63:0] i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_phase,
    input  logic signed [31:0] i_pos_x,
    input  logic signed [31:0] i_pos_y,
    input  logic signed [31:0] i_pos_z,
    input  logic signed [31:0] i_aux_x,
    input  logic signed [31:0] i_aux_y,
    input  logic signed [31:0] i_aux_z,
    input  logic signed [31:0] i_vel_x,
    input  logic signed [31:0] i_vel_y,
    input  logic signed [31:0] i_vel_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_new_pos_x,
    output logic signed [31:0] o_new_pos_y,
    output logic signed [31:0] o_new_pos_z,
    output logic signed [31:0] o_new_aux_x,
    output logic signed [31:0] o_new_aux_y,
    output logic signed [31:0] o_new_aux_z,
    output logic signed [31:0] o_new_vel_x,
    output logic signed [31:0] o_new_vel_y,
    output logic signed [31:0] o_new_vel_z,
    output logic        [5:0]  o_image_shift,
    output logic        [4:0]  o_neighbour_tag
);

    `include "particle_wall_boundary_classifier_top_assert.svh"

    // configuration registers
    logic [2:0]  r_periodic_mask, n_periodic_mask;
    logic [30:0] r_domain_len [NUM_AXES];
    logic [30:0] n_domain_len [NUM_AXES];
    logic [63:0] r_sub_bounds [NUM_AXES];
    logic [63:0] n_sub_bounds [NUM_AXES];

    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_periodic_mask = r_periodic_mask;
        n_domain_len    = r_domain_len;
        n_sub_bounds    = r_sub_bounds;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PERIODIC_MASK: n_periodic_mask = i_cfg_data[2:0];
                CFG_DOMAIN_LEN_X:  n_domain_len[0] = i_cfg_data[30:0];
                CFG_DOMAIN_LEN_Y:  n_domain_len[1] = i_cfg_data[30:0];
                CFG_DOMAIN_LEN_Z:  n_domain_len[2] = i_cfg_data[30:0];
                CFG_SUB_BOUNDS_X:  n_sub_bounds[0] = i_cfg_data;
                CFG_SUB_BOUNDS_Y:  n_sub_bounds[1] = i_cfg_data;
                CFG_SUB_BOUNDS_Z:  n_sub_bounds[2] = i_cfg_data;
                default: begin
                    // drop writes beyond the register list
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_periodic_mask <= '0;
            for (int ax = 0; ax < NUM_AXES; ax++) begin
                r_domain_len[ax] <= '0;
                r_sub_bounds[ax] <= '0;
            end
        end else begin
            r_periodic_mask <= n_periodic_mask;
            r_domain_len    <= n_domain_len;
            r_sub_bounds    <= n_sub_bounds;
        end
    end

    // pipeline control: each stage loads when it is empty or its item moves on
    logic [3:0] r_vld, n_vld;
    logic [3:0] stage_rdy;
    t_pipe_en   pipe_en;

    always_comb begin
        stage_rdy[3] = !r_vld[3] || !i_out_stall;
        stage_rdy[2] = !r_vld[2] || stage_rdy[3];
        stage_rdy[1] = !r_vld[1] || stage_rdy[2];
        stage_rdy[0] = !r_vld[0] || stage_rdy[1];

        pipe_en.s1  = stage_rdy[0];
        pipe_en.s2  = stage_rdy[1];
        pipe_en.s3  = stage_rdy[2];
        pipe_en.out = stage_rdy[3];

        n_vld[0] = stage_rdy[0] ? i_in_valid : r_vld[0];
        n_vld[1] = stage_rdy[1] ? r_vld[0]   : r_vld[1];
        n_vld[2] = stage_rdy[2] ? r_vld[1]   : r_vld[2];
        n_vld[3] = stage_rdy[3] ? r_vld[2]   : r_vld[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !stage_rdy[0];
    assign o_out_valid = r_vld[3];

    // axis lanes
    t_lane_in  lane_in  [NUM_AXES];
    t_axis_cfg lane_cfg [NUM_AXES];
    t_lane_out lane_out [NUM_AXES];

    assign lane_in[0] = '{pos: i_pos_x, aux: i_aux_x, vel: i_vel_x};
    assign lane_in[1] = '{pos: i_pos_y, aux: i_aux_y, vel: i_vel_y};
    assign lane_in[2] = '{pos: i_pos_z, aux: i_aux_z, vel: i_vel_z};

    for (genvar ax = 0; ax < NUM_AXES; ax++) begin : g_lane
        assign lane_cfg[ax].periodic = r_periodic_mask[ax];
        assign lane_cfg[ax].len      = r_domain_len[ax];
        assign lane_cfg[ax].lo       = r_sub_bounds[ax][31:0];
        assign lane_cfg[ax].hi       = r_sub_bounds[ax][63:32];

        pwbc_lane #(
            .POS_WIDTH(POS_WIDTH)
        ) u_lane (
            .i_clk   (i_clk),
            .i_en    (pipe_en),
            .i_phase (i_phase),
            .i_in    (lane_in[ax]),
            .i_cfg   (lane_cfg[ax]),
            .o_out   (lane_out[ax])
        );
    end

    logic signed [31:0] out_pos [NUM_AXES];
    logic signed [31:0] out_aux [NUM_AXES];
    logic signed [31:0] out_vel [NUM_AXES];

    pwbc_merge u_merge (
        .i_clk           (i_clk),
        .i_en            (pipe_en.out),
        .i_lane          (lane_out),
        .o_pos           (out_pos),
        .o_aux           (out_aux),
        .o_vel           (out_vel),
        .o_image_shift   (o_image_shift),
        .o_neighbour_tag (o_neighbour_tag)
    );

    assign o_new_pos_x = out_pos[0];
    assign o_new_pos_y = out_pos[1];
    assign o_new_pos_z = out_pos[2];
    assign o_new_aux_x = out_aux[0];
    assign o_new_aux_y = out_aux[1];
    assign o_new_aux_z = out_aux[2];
    assign o_new_vel_x = out_vel[0];
    assign o_new_vel_y = out_vel[1];
    assign o_new_vel_z = out_vel[2];

    `PWBC_ASSERT_SAME(a_tag_range, i_clk, i_rst_n, o_out_valid,
        o_neighbour_tag <= MAX_TAG, "neighbour tag out of range")
    `PWBC_ASSERT_SAME(a_stay_no_shift, i_clk, i_rst_n,
        o_out_valid && (o_neighbour_tag == STAY_TAG),
        o_image_shift == 6'd0, "image shift on a staying particle")
    `PWBC_ASSERT_SAME(a_wall_no_shift, i_clk, i_rst_n,
        o_out_valid && !r_periodic_mask[0] && !r_periodic_mask[1] && !r_periodic_mask[2],
        o_image_shift == 6'd0, "image shift with all walls reflecting")
    `PWBC_ASSERT_NEXT(a_accept_lands, i_clk, i_rst_n, i_in_valid && !o_in_stall,
        r_vld[0], "accepted item lost at first stage")

endmodule
